// File: rtl/core/sssa_pkg.sv
// ----------------------------------------------------------------------------
// sssa_pkg
// Shared types and constants of the sparse score scatter accumulator.
// ----------------------------------------------------------------------------
package sssa_pkg;

	localparam int SCORE_ENTRIES = 65536;
	localparam int ADDR_W        = $clog2(SCORE_ENTRIES);
	localparam int SCORE_W       = 48;
	localparam int NODE_W        = 17;
	localparam int IDX_EXT_W     = NODE_W + ADDR_W + 1;
	localparam int WEIGHT_W      = 16;
	localparam int OFFSET_W      = 16;
	localparam int BASE_W        = 16;
	localparam int MUL_W         = 32;
	localparam int S_DATA_W      = 80;
	localparam int M_DATA_W      = 56;

	localparam logic [NODE_W-1:0] NODE_COUNT_RESET = NODE_W'(65536);

	localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ACT_ACCUM = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef struct packed {
		logic              active;
		logic [ADDR_W-1:0] addr;
	} clr_t;

endpackage

// File: rtl/core/sssa_ram.sv
// ----------------------------------------------------------------------------
// sssa_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module sssa_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/sssa_clear.sv
// ----------------------------------------------------------------------------
// sssa_clear
// Sweeps the score memory after reset and writes every entry to zero.
// ----------------------------------------------------------------------------
module sssa_clear import sssa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	output clr_t clr
);

	logic              active_q;
	logic [ADDR_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (active_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ADDR_W'(SCORE_ENTRIES - 1)) begin
				active_q <= 1'b0;
			end
		end
	end

	assign clr.active = active_q;
	assign clr.addr   = cnt_q;

endmodule

// File: rtl/core/sparse_score_scatter_accumulate.sv
// ----------------------------------------------------------------------------
// sparse_score_scatter_accumulate
// Scatter-add accumulator of saturating Q31.16 scores, one per node.
// ----------------------------------------------------------------------------
// Postings arrive on the s_ stream, one word per item. s_tuser carries the
// action (accumulate, read, clear), s_tlast marks the end of a posting list.
// Every word yields exactly one result word on the m_ stream with the score
// of the addressed node after the action, the in-range and saturation flags,
// and s_tlast echoed on m_tlast.
// The scores live in one memory with a registered read. A word is accepted,
// its entry is read in that cycle, and in the next cycle, if the output
// register is free or being emptied, the sum is formed, written back and
// placed in the output register. The next word is taken only after the
// previous write-back, so no two accesses to an entry overlap.
// The output register lets a new word be accepted while a result waits. If
// the receiver stalls, the item in flight holds until the output register
// frees, and s_tready stays low meanwhile.
// After reset the memory is cleared one entry per cycle, all 65536 entries,
// with s_tready low. cfg_we writes node_count at any time and it resets to 65536.
// ----------------------------------------------------------------------------
module sparse_score_scatter_accumulate import sssa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [NODE_W-1:0]   cfg_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	// Fields from bit 0: weight, offset, base, term_mul.
	input  logic [S_DATA_W-1:0] s_tdata,
	// Fields from bit 0: action.
	input  logic [1:0]          s_tuser,
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	// Fields from bit 0: score, in_range, saturated, zero fill.
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tlast
);

	clr_t clr;

	logic [NODE_W-1:0] node_count_q;

	logic                        busy_s1;
	action_t                     act_s1;
	logic                        hit_s1;
	logic signed [SCORE_W-1:0]   prod_s1;
	logic [ADDR_W-1:0]           addr_s1;
	logic                        last_s1;

	logic                        m_valid_q;
	logic signed [SCORE_W-1:0]   score_q;
	logic                        in_range_q;
	logic                        sat_q;
	logic                        last_q;

	logic                        in_acc;
	logic                        done_s1;
	logic [WEIGHT_W-1:0]         in_weight;
	logic [OFFSET_W-1:0]         in_offset;
	logic [BASE_W-1:0]           in_base;
	logic signed [MUL_W-1:0]     in_mul;
	logic [NODE_W-1:0]           node;
	logic [IDX_EXT_W-1:0]        node_ext;
	logic                        node_valid;
	logic                        in_hit;
	logic signed [SCORE_W:0]     prod_full;
	logic [SCORE_W-1:0]          rdata;
	logic signed [SCORE_W:0]     sum;
	logic signed [SCORE_W-1:0]   clamped;
	logic                        ovf;
	logic signed [SCORE_W-1:0]   res_score;
	logic                        res_sat;
	logic                        upd;
	logic                        ram_we;
	logic [ADDR_W-1:0]           ram_waddr;
	logic [SCORE_W-1:0]          ram_wdata;

	sssa_clear u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr)
	);

	assign in_weight = s_tdata[15:0];
	assign in_offset = s_tdata[31:16];
	assign in_base   = s_tdata[47:32];
	assign in_mul    = $signed(s_tdata[79:48]);

	assign s_tready = !clr.active && !busy_s1;
	assign in_acc   = s_tvalid && s_tready;
	assign done_s1  = busy_s1 && (!m_valid_q || m_tready);

	assign node       = NODE_W'(in_base) + NODE_W'(in_offset);
	assign node_ext   = IDX_EXT_W'(node);
	assign node_valid = (node < node_count_q) && (node_ext < IDX_EXT_W'(SCORE_ENTRIES));
	assign prod_full  = $signed({1'b0, in_weight}) * in_mul;

	always_comb begin
		case (s_tuser) inside
			ACT_ACCUM, ACT_READ, ACT_CLEAR: in_hit = node_valid;
			default:                        in_hit = 1'b0;
		endcase
	end

	assign sum     = $signed({rdata[SCORE_W-1], rdata}) + $signed({prod_s1[SCORE_W-1], prod_s1});
	assign ovf     = sum[SCORE_W] != sum[SCORE_W-1];
	assign clamped = ovf ? (sum[SCORE_W] ? SCORE_MIN : SCORE_MAX) : sum[SCORE_W-1:0];

	always_comb begin
		res_score = '0;
		res_sat   = 1'b0;
		upd       = 1'b0;
		if (hit_s1) begin
			unique case (act_s1)
				ACT_ACCUM: begin
					res_score = clamped;
					res_sat   = ovf;
					upd       = 1'b1;
				end
				ACT_READ: begin
					res_score = $signed(rdata);
				end
				ACT_CLEAR: begin
					upd = 1'b1;
				end
				default: begin
					upd = 1'b0;
				end
			endcase
		end
	end

	assign ram_we    = clr.active || (done_s1 && upd);
	assign ram_waddr = clr.active ? clr.addr : addr_s1;
	assign ram_wdata = clr.active ? '0 : res_score;

	sssa_ram #(
		.WIDTH (SCORE_W),
		.DEPTH (SCORE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_acc),
		.raddr (node_ext[ADDR_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (in_acc) begin
			busy_s1 <= 1'b1;
		end else if (done_s1) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_s1  <= action_t'(s_tuser);
			hit_s1  <= in_hit;
			prod_s1 <= prod_full[SCORE_W-1:0];
			addr_s1 <= node_ext[ADDR_W-1:0];
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (done_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1) begin
			score_q    <= res_score;
			in_range_q <= hit_s1;
			sat_q      <= res_sat;
			last_q     <= last_s1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_DATA_W-SCORE_W-2){1'b0}}, sat_q, in_range_q, score_q};
	assign m_tlast  = last_q;

endmodule

// File: tb/sparse_score_scatter_accumulate_tb.sv
// ----------------------------------------------------------------------------
// sparse_score_scatter_accumulate_tb
// Self-checking bench for the saturating per-node score accumulator.
// ----------------------------------------------------------------------------
// Postings are driven on the input stream and every accepted word is run
// through a behavioral score table kept in the bench. Each result word is
// compared field by field with the oldest pending prediction. Directed
// postings cover the field extremes, each action, saturation and the range
// limits; random traffic then runs under several node counts and idle
// patterns, followed by a long output stall and a full drain.
// ----------------------------------------------------------------------------
module sparse_score_scatter_accumulate_tb import sssa_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACT_UNUSED   = 2'd3;
	localparam int         DRAIN_CYCLES = 8;
	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         PHASE_ITEMS  = 135;
	localparam int         MAX_PRINTS   = 50;

	typedef struct {
		logic [1:0]           action;
		logic [WEIGHT_W-1:0]  weight;
		logic [OFFSET_W-1:0]  offset;
		logic [BASE_W-1:0]    base;
		logic signed [MUL_W-1:0] term_mul;
		logic                 last;
	} posting_t;

	typedef struct {
		logic signed [SCORE_W-1:0] score;
		logic                      in_range;
		logic                      saturated;
		logic                      done;
	} score_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [NODE_W-1:0]   cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	// Fields from bit 0: weight, offset, base, term_mul.
	logic [S_DATA_W-1:0] s_tdata;
	// Fields from bit 0: action.
	logic [1:0]          s_tuser;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	// Fields from bit 0: score, in_range, saturated, zero fill.
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;

	logic signed [SCORE_W-1:0] node_scores [SCORE_ENTRIES];
	logic [NODE_W-1:0]         node_limit;
	score_result_t             expected_results [$];
	int                        hot_nodes [8];

	int err_count;
	int sent_count;
	int sat_seen;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	int cycles;

	sparse_score_scatter_accumulate dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic score_result_t predict_posting(input posting_t p);
		score_result_t     r;
		logic [NODE_W-1:0] node;
		logic [ADDR_W-1:0] idx;
		longint            total;
		node  = {1'b0, p.base} + {1'b0, p.offset};
		idx   = node[ADDR_W-1:0];
		r.score     = '0;
		r.in_range  = 1'b0;
		r.saturated = 1'b0;
		r.done      = p.last;
		if (node < node_limit && node < SCORE_ENTRIES && p.action != ACT_UNUSED) begin
			r.in_range = 1'b1;
			if (p.action == ACT_ACCUM) begin
				total = longint'(node_scores[idx]) + longint'(p.weight) * longint'(p.term_mul);
				if (total > longint'(SCORE_MAX)) begin
					total       = longint'(SCORE_MAX);
					r.saturated = 1'b1;
				end else if (total < longint'(SCORE_MIN)) begin
					total       = longint'(SCORE_MIN);
					r.saturated = 1'b1;
				end
				node_scores[idx] = SCORE_W'(total);
				r.score          = SCORE_W'(total);
			end else if (p.action == ACT_READ) begin
				r.score = node_scores[idx];
			end else begin
				node_scores[idx] = '0;
			end
		end
		return r;
	endfunction

	function automatic posting_t make_posting(input logic [1:0] action, input int weight,
			input int offset, input int base, input int term_mul, input bit last);
		posting_t p;
		p.action   = action;
		p.weight   = WEIGHT_W'(weight);
		p.offset   = OFFSET_W'(offset);
		p.base     = BASE_W'(base);
		p.term_mul = MUL_W'(term_mul);
		p.last     = last;
		return p;
	endfunction

	function automatic posting_t make_random_posting();
		posting_t p;
		int       node;
		int       base_lo;
		int       base_hi;
		int       pick;
		p.last = ($urandom_range(7) == 0);
		if ($urandom_range(99) < 75) begin
			node    = hot_nodes[$urandom_range(7)];
			base_lo = (node > 65535) ? node - 65535 : 0;
			base_hi = (node < 65535) ? node : 65535;
			p.base   = BASE_W'($urandom_range(base_hi, base_lo));
			p.offset = OFFSET_W'(node - int'(p.base));
			pick = $urandom_range(99);
			if (pick < 60)
				p.action = ACT_ACCUM;
			else if (pick < 80)
				p.action = ACT_READ;
			else if (pick < 93)
				p.action = ACT_CLEAR;
			else
				p.action = ACT_UNUSED;
			if ($urandom_range(1) == 0)
				p.weight = WEIGHT_W'($urandom_range(255));
			else
				p.weight = WEIGHT_W'($urandom);
			if ($urandom_range(3) == 0)
				p.term_mul = MUL_W'($urandom);
			else
				p.term_mul = MUL_W'(int'($urandom_range(32'h200000)) - 32'h100000);
		end else begin
			p.action   = 2'($urandom);
			p.weight   = WEIGHT_W'($urandom);
			p.offset   = OFFSET_W'($urandom);
			p.base     = BASE_W'($urandom);
			p.term_mul = MUL_W'($urandom);
		end
		return p;
	endfunction

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	task automatic send_word(input posting_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= p.action;
		s_tlast  <= p.last;
		s_tdata  <= {p.term_mul, p.base, p.offset, p.weight};
		do
			@(posedge clk);
		while (!s_tready);
		expected_results.push_back(predict_posting(p));
		sent_count++;
		@(negedge clk);
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_node_count(input int value);
		wait_results_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= NODE_W'(value);
		@(negedge clk);
		cfg_we     <= 1'b0;
		node_limit  = NODE_W'(value);
		@(negedge clk);
	endtask

	task automatic test_directed_postings();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_word(make_posting(ACT_ACCUM, 16'hFFFF, 0, 0, 32'h7FFFFFFF, 1'b0));
		send_word(make_posting(ACT_ACCUM, 16'hFFFF, 0, 0, 32'h7FFFFFFF, 1'b0));
		send_word(make_posting(ACT_READ, 0, 0, 0, 0, 1'b1));
		send_word(make_posting(ACT_CLEAR, 16'hFFFF, 0, 0, 32'h7FFFFFFF, 1'b0));
		send_word(make_posting(ACT_READ, 0, 0, 0, 0, 1'b0));
		send_word(make_posting(ACT_ACCUM, 16'hFFFF, 1, 0, 32'h80000000, 1'b0));
		send_word(make_posting(ACT_ACCUM, 16'hFFFF, 0, 1, 32'h80000000, 1'b0));
		send_word(make_posting(ACT_READ, 0, 1, 0, 0, 1'b1));
		send_word(make_posting(ACT_ACCUM, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7FFFFFFF, 1'b0));
		send_word(make_posting(ACT_ACCUM, 1, 0, 16'hFFFF, 1, 1'b0));
		send_word(make_posting(ACT_ACCUM, 0, 16'hFFFF, 0, -1, 1'b0));
		send_word(make_posting(ACT_READ, 0, 16'hFFFF, 1, 0, 1'b1));
		send_word(make_posting(ACT_READ, 0, 16'hFFFF, 0, 0, 1'b0));
		send_word(make_posting(ACT_UNUSED, 16'hFFFF, 1, 0, 32'h7FFFFFFF, 1'b1));
		send_word(make_posting(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, -1, 1'b0));
		send_word(make_posting(ACT_CLEAR, 0, 16'hFFFF, 16'hFFFF, 0, 1'b1));
		send_word(make_posting(ACT_ACCUM, 0, 2, 0, 32'h7FFFFFFF, 1'b0));
		send_word(make_posting(ACT_ACCUM, 16'h00FF, 2, 0, 32'h00010000, 1'b0));
		send_word(make_posting(ACT_ACCUM, 1, 0, 2, -1, 1'b0));
		send_word(make_posting(ACT_READ, 0, 1, 1, 0, 1'b1));
		send_word(make_posting(ACT_CLEAR, 0, 0, 1, 0, 1'b0));
		send_word(make_posting(ACT_READ, 0, 0, 1, 0, 1'b1));
	endtask

	task automatic test_node_count_limits();
		int mid;
		mid = $urandom_range(65534, 2);
		write_node_count(0);
		send_word(make_posting(ACT_ACCUM, 5, 0, 0, 32'h00010000, 1'b0));
		send_word(make_posting(ACT_READ, 0, 0, 0, 0, 1'b1));
		write_node_count(1);
		send_word(make_posting(ACT_ACCUM, 3, 0, 0, 32'h00010000, 1'b0));
		send_word(make_posting(ACT_READ, 0, 1, 0, 0, 1'b1));
		write_node_count(131071);
		send_word(make_posting(ACT_ACCUM, 7, 0, 16'hFFFF, 32'h00020000, 1'b0));
		send_word(make_posting(ACT_READ, 0, 16'h8000, 16'h8000, 0, 1'b1));
		write_node_count(65535);
		send_word(make_posting(ACT_READ, 0, 16'hFFFE, 0, 0, 1'b0));
		send_word(make_posting(ACT_ACCUM, 9, 0, 16'hFFFF, 32'h00010000, 1'b1));
		write_node_count(mid);
		send_word(make_posting(ACT_ACCUM, 2, 0, mid - 1, -32'h00010000, 1'b0));
		send_word(make_posting(ACT_READ, 0, 0, mid, 0, 1'b1));
		write_node_count(65536);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
		int edge_node;
		wait_results_drained();
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < 8; i++) begin
			edge_node = int'(node_limit) - 2 + (i - 4);
			if (edge_node < 0)
				edge_node = 0;
			if (edge_node > 131070)
				edge_node = 131070;
			hot_nodes[i] = (i < 4) ? $urandom_range(65535) : edge_node;
		end
		repeat (count) send_word(make_random_posting());
	endtask

	task automatic test_output_backpressure();
		wait_results_drained();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_cycles = 300;
		@(negedge clk);
		repeat (30) send_word(make_random_posting());
		wait_results_drained();
		repeat (10) send_word(make_random_posting());
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles--;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		score_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result word %h", m_tdata));
			end else begin
				exp_r = expected_results.pop_front();
				if (m_tdata[SCORE_W-1:0] !== exp_r.score)
					report_mismatch($sformatf("score %h, expected %h",
						m_tdata[SCORE_W-1:0], exp_r.score));
				if (m_tdata[SCORE_W] !== exp_r.in_range)
					report_mismatch($sformatf("in_range %b, expected %b",
						m_tdata[SCORE_W], exp_r.in_range));
				if (m_tdata[SCORE_W+1] !== exp_r.saturated)
					report_mismatch($sformatf("saturated %b, expected %b",
						m_tdata[SCORE_W+1], exp_r.saturated));
				if (m_tlast !== exp_r.done)
					report_mismatch($sformatf("done %b, expected %b", m_tlast, exp_r.done));
				if (exp_r.saturated)
					sat_seen++;
			end
		end
	end

	initial begin : watchdog
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("Timeout after %0d cycles", CYCLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		s_tlast        = 1'b0;
		m_tready       = 1'b0;
		err_count      = 0;
		sent_count     = 0;
		sat_seen       = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = 0;
		node_limit     = NODE_COUNT_RESET;
		foreach (node_scores[i])
			node_scores[i] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_postings();
		test_node_count_limits();
		test_random_traffic(0, 0, PHASE_ITEMS);
		write_node_count($urandom_range(65534, 2));
		test_random_traffic(65, 0, PHASE_ITEMS);
		write_node_count(131071);
		test_random_traffic(0, 65, PHASE_ITEMS);
		write_node_count(65536);
		test_random_traffic(31, 31, PHASE_ITEMS);
		test_output_backpressure();

		wait_results_drained();
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		$display("Sent %0d postings (accumulate, read, clear, unused code, out of range),",
			sent_count);
		$display("saw %0d saturated sums, across several node counts and four idle patterns.",
			sat_seen);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
